// File: src/isfp_pkg.sv
`default_nettype none
package isfp_pkg;

    localparam int NUM_CH = 3;
    localparam int CH_W   = 8;
    localparam int CFG_DW = 12;
    localparam int IDX_W  = 2;

    typedef logic [CH_W-1:0]         t_chan;
    typedef t_chan [NUM_CH-1:0]      t_pix;
    typedef logic [IDX_W-1:0]        t_reg_idx;

    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;
    localparam t_reg_idx REG_COLOR  = 2'd2;

    localparam logic [CFG_DW-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_DW-1:0] RST_HEIGHT = 12'd480;
    localparam logic [CFG_DW-1:0] HEIGHT_MAX = 12'd2048;
    localparam t_chan             CH_MAX     = 8'hFF;

endpackage
`default_nettype wire

// File: src/image_sharpen_five_point.sv
`default_nettype none
// Latency: a result is registered as the transaction completing its window leaves
// the window stage, image_width + 1 input transactions after its pixel. Throughput:
// one input transaction per clock unless output back-pressure stalls, set by the simple
// dual-port line stores (one read plus one write per row store each cycle) and the three
// channel lanes. Reset (synchronous, active low): sizes 640x480, color on, frame
// position zero, pipeline empty. Line store contents are not cleared.
module image_sharpen_five_point #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire isfp_pkg::t_reg_idx      i_cfg_idx,
    input  wire logic [isfp_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_mode,
    input  wire isfp_pkg::t_chan         i_chan0,
    input  wire isfp_pkg::t_chan         i_chan1,
    input  wire isfp_pkg::t_chan         i_chan2,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output isfp_pkg::t_chan              o_out0,
    output isfp_pkg::t_chan              o_out1,
    output isfp_pkg::t_chan              o_out2,
    output logic                         o_frame_end
);
    import isfp_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = (AW > CFG_DW) ? AW : CFG_DW;

    typedef struct packed {
        logic emit;
        logic interior;
        logic frame_end;
    } t_ctl;

    logic [CFG_DW-1:0] r_width;
    logic [CFG_DW-1:0] r_height;
    logic              r_color;
    logic [AW-1:0]     r_in_col;
    logic [AW-1:0]     n_in_col;
    logic [CFG_DW-1:0] r_in_row;
    logic [CFG_DW-1:0] n_in_row;

    logic [CFG_DW-1:0] w_eff;
    logic [CFG_DW-1:0] h_eff;
    logic              col_last;
    logic              accept;
    t_ctl              ctl;
    t_pix              px;

    logic              r_s1_vld;
    t_ctl              r_s1_ctl;
    t_pix              r_s1_px;
    logic              s1_adv;
    t_pix              up_rd;
    t_pix              mid_rd;

    t_pix              r_w11;
    t_pix              r_w02;
    t_pix              r_w12;
    t_pix              r_w22;
    t_pix              lane_res;

    logic              r_out_vld;
    t_pix              r_out;
    logic              r_out_fe;
    logic              out_load;

    // effective frame size
    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_DW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = CFG_DW'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = CFG_DW'(1);
        end else if (r_height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
    end

    assign accept   = i_in_valid && o_in_ready;
    assign col_last = (XW'(r_in_col) == (XW'(w_eff) - XW'(1)));

    always_comb begin
        ctl.emit      = !((r_in_row == '0) || ((r_in_row == CFG_DW'(1)) && (r_in_col == '0)));
        ctl.interior  = (r_in_col >= AW'(2)) && (r_in_row >= CFG_DW'(2))
                        && (r_in_row < h_eff);
        ctl.frame_end = (r_in_row == (h_eff + CFG_DW'(1))) && (r_in_col == '0);
        if (!i_mode && (r_in_row < h_eff)) begin
            px = {i_chan2, i_chan1, i_chan0};
        end else begin
            px = '0;
        end
    end

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT))) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (accept) begin
            if (ctl.frame_end) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + CFG_DW'(1);
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_color  <= 1'b1;
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_COLOR:  r_color  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    isfp_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_addr  (r_in_col),
        .i_px    (px),
        .o_up    (up_rd),
        .o_mid   (mid_rd)
    );

    // window stage
    assign s1_adv     = r_s1_vld && (!r_s1_ctl.emit || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign out_load   = s1_adv && r_s1_ctl.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= ctl;
            r_s1_px  <= px;
        end
        if (s1_adv) begin
            r_w11 <= r_w12;
            r_w02 <= up_rd;
            r_w12 <= mid_rd;
            r_w22 <= r_s1_px;
        end
    end

    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        isfp_lane u_lane (
            .i_centre   (r_w12[k]),
            .i_up       (r_w02[k]),
            .i_down     (r_w22[k]),
            .i_left     (r_w11[k]),
            .i_right    (mid_rd[k]),
            .i_interior (r_s1_ctl.interior),
            .o_res      (lane_res[k])
        );
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out[0] <= lane_res[0];
            r_out[1] <= r_color ? lane_res[1] : '0;
            r_out[2] <= r_color ? lane_res[2] : '0;
            r_out_fe <= r_s1_ctl.frame_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out0      = r_out[0];
    assign o_out1      = r_out[1];
    assign o_out2      = r_out[2];
    assign o_frame_end = r_out_fe;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_in_col) < XW'(w_eff))
        else $error("column counter beyond row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= (h_eff + CFG_DW'(1)))
        else $error("row counter beyond frame end");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ctl.frame_end |=> (r_in_row == '0) && (r_in_col == '0))
        else $error("frame position not cleared after frame end");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |-> !accept)
        else $error("transaction accepted while window stage is stalled");

endmodule
`default_nettype wire

// File: src/isfp_lane.sv
`default_nettype none
module isfp_lane (
    input  wire isfp_pkg::t_chan i_centre,
    input  wire isfp_pkg::t_chan i_up,
    input  wire isfp_pkg::t_chan i_down,
    input  wire isfp_pkg::t_chan i_left,
    input  wire isfp_pkg::t_chan i_right,
    input  wire logic            i_interior,
    output isfp_pkg::t_chan      o_res
);
    import isfp_pkg::*;

    localparam int SW = CH_W + 3;

    logic [SW-1:0] pos;
    logic [SW-1:0] neg;
    logic [SW-1:0] diff;

    // 5*c against the four orthogonal neighbors, clamped to a byte; border pixels pass c through
    always_comb begin
        pos  = (SW'(i_centre) << 2) + SW'(i_centre);
        neg  = SW'(i_up) + SW'(i_down) + SW'(i_left) + SW'(i_right);
        diff = pos - neg;
        if (!i_interior) begin
            o_res = i_centre;
        end else if (neg > pos) begin
            o_res = '0;
        end else if (diff > SW'(CH_MAX)) begin
            o_res = CH_MAX;
        end else begin
            o_res = diff[CH_W-1:0];
        end
    end

endmodule
`default_nettype wire

// File: src/isfp_linebuf.sv
`default_nettype none
module isfp_linebuf #(
    parameter int MAX_WIDTH = 2048,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_addr,
    input  wire isfp_pkg::t_pix  i_px,
    output isfp_pkg::t_pix       o_up,
    output isfp_pkg::t_pix       o_mid
);
    import isfp_pkg::*;

    t_pix          r_mem_up  [MAX_WIDTH];
    t_pix          r_mem_mid [MAX_WIDTH];
    t_pix          r_up_rd;
    t_pix          r_mid_rd;
    logic [AW-1:0] r_addr;
    logic          r_up_we;

    // middle row: read old entry and store the new pixel in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_rd            <= r_mem_mid[i_addr];
            r_mem_mid[i_addr]   <= i_px;
            r_addr              <= i_addr;
        end
    end

    // upper row: takes the old middle entry in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_rd <= r_mem_up[i_addr];
        end
        if (r_up_we) begin
            r_mem_up[r_addr] <= r_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_we <= 1'b0;
        end else begin
            r_up_we <= i_rd_en;
        end
    end

    assign o_up  = r_up_rd;
    assign o_mid = r_mid_rd;

endmodule
`default_nettype wire
